### hdl/lfu_cache_controller_unit_defines.svh
// Assertion helpers for the LFU cache controller.
`ifndef LFU_CACHE_CONTROLLER_UNIT_DEFINES_SVH
`define LFU_CACHE_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define LFU_ASSERT_NOW(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error(msg);

// Next-cycle implication.
`define LFU_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error(msg);

`endif

### hdl/lfu_pkg.sv
package lfu_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int CNT_W       = 16;
  localparam int CAP_W       = 5;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  localparam logic [CNT_W-1:0] CNT_MAX   = '1;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // register index, taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic {
    ACT_GET = 1'b0,
    ACT_PUT = 1'b1
  } action_t;

  typedef struct packed {
    action_t                   action;
    logic [KEY_W-1:0]          key;
    logic signed [VAL_W-1:0]   value;
  } req_t;

  typedef struct packed {
    logic                      hit;
    logic signed [VAL_W-1:0]   read_value;
    logic                      evicted;
    logic [KEY_W-1:0]          evicted_key;
  } rsp_t;

endpackage

### hdl/lfu_cfg.sv
module lfu_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lfu_pkg::APB_AW-1:0]  paddr,
  input  logic [lfu_pkg::APB_DW-1:0]  pwdata,
  output logic [lfu_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output logic [lfu_pkg::CAP_W-1:0]   capacity
);
  import lfu_pkg::*;

  logic wr_cap;

  assign pready = 1'b1;
  assign wr_cap = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (wr_cap) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CAPACITY) begin
      prdata = {{(APB_DW-CAP_W){1'b0}}, capacity};
    end
  end

endmodule

### hdl/lfu_victim_sel.sv
module lfu_victim_sel #(
  parameter int ENTRIES = lfu_pkg::ENTRIES_DEF,
  parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic [ENTRIES-1:0]              valid,
  input  logic [lfu_pkg::CNT_W-1:0]       count [ENTRIES],
  input  logic [IDX_W-1:0]                rank  [ENTRIES],
  output logic                            any,
  output logic [IDX_W-1:0]                idx
);
  import lfu_pkg::*;

  localparam int LEVELS = $clog2(ENTRIES);
  localparam int LEAVES = 1 << LEVELS;
  localparam int NODES  = 2 * LEAVES - 1;

  logic             nv [NODES];
  logic [CNT_W-1:0] nc [NODES];
  logic [IDX_W-1:0] nr [NODES];
  logic [IDX_W-1:0] ni [NODES];

  for (genvar l = 0; l < LEAVES; l++) begin : g_leaf
    if (l < ENTRIES) begin : g_used
      assign nv[LEAVES-1+l] = valid[l];
      assign nc[LEAVES-1+l] = count[l];
      assign nr[LEAVES-1+l] = rank[l];
    end else begin : g_pad
      assign nv[LEAVES-1+l] = 1'b0;
      assign nc[LEAVES-1+l] = '0;
      assign nr[LEAVES-1+l] = '0;
    end
    assign ni[LEAVES-1+l] = IDX_W'(l);
  end

  // lowest count wins, oldest use (largest rank) breaks a tie
  for (genvar n = 0; n < LEAVES - 1; n++) begin : g_node
    logic take_r;
    assign take_r = nv[2*n+2] && (!nv[2*n+1] || (nc[2*n+2] < nc[2*n+1]) ||
                    ((nc[2*n+2] == nc[2*n+1]) && (nr[2*n+2] > nr[2*n+1])));
    assign nv[n] = nv[2*n+1] || nv[2*n+2];
    assign nc[n] = take_r ? nc[2*n+2] : nc[2*n+1];
    assign nr[n] = take_r ? nr[2*n+2] : nr[2*n+1];
    assign ni[n] = take_r ? ni[2*n+2] : ni[2*n+1];
  end

  assign any = nv[0];
  assign idx = ni[0];

endmodule

### hdl/lfu_store.sv
module lfu_store #(
  parameter int ENTRIES = lfu_pkg::ENTRIES_DEF,
  parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  parameter int OCC_W   = $clog2(ENTRIES + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_vld,
  input  lfu_pkg::req_t      req,
  input  logic [OCC_W-1:0]   cap_eff,
  output lfu_pkg::rsp_t      rsp,
  output logic [ENTRIES-1:0] valid,
  output logic [OCC_W-1:0]   occupied
);
  import lfu_pkg::*;

  logic [KEY_W-1:0]        ekey   [ENTRIES];
  logic signed [VAL_W-1:0] evalue [ENTRIES];
  logic [CNT_W-1:0]        ecount [ENTRIES];
  logic [IDX_W-1:0]        erank  [ENTRIES];

  logic [ENTRIES-1:0]      match;
  logic [ENTRIES-1:0]      vsel;
  logic [ENTRIES-1:0]      free;
  logic [ENTRIES-1:0]      slot_oh;
  logic                    found;
  logic signed [VAL_W-1:0] fval;
  logic [IDX_W-1:0]        frank;
  logic [KEY_W-1:0]        vkey;
  logic [IDX_W-1:0]        vrank;
  logic                    vict_any;
  logic [IDX_W-1:0]        vict_idx;
  logic                    is_get;
  logic                    cap_zero;
  logic                    do_touch;
  logic                    do_ins;
  logic                    do_evict;
  logic                    ins;
  logic                    inc_all;
  logic [IDX_W-1:0]        thr;

  lfu_victim_sel #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_victim (
    .valid (valid),
    .count (ecount),
    .rank  (erank),
    .any   (vict_any),
    .idx   (vict_idx)
  );

  always_comb begin
    match = '0;
    vsel  = '0;
    fval  = '0;
    frank = '0;
    vkey  = '0;
    vrank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid[i] && (ekey[i] == req.key);
      vsel[i]  = (vict_idx == IDX_W'(i));
      fval  = fval  | (match[i] ? evalue[i] : '0);
      frank = frank | (match[i] ? erank[i]  : '0);
      vkey  = vkey  | (vsel[i]  ? ekey[i]   : '0);
      vrank = vrank | (vsel[i]  ? erank[i]  : '0);
    end
  end

  assign found    = |match;
  assign is_get   = (req.action == ACT_GET);
  assign cap_zero = (cap_eff == '0);
  assign do_touch = in_vld && found && (is_get || !cap_zero);
  assign do_ins   = in_vld && !found && !is_get && !cap_zero;
  assign do_evict = do_ins && (occupied >= cap_eff) && vict_any;

  // lowest free entry, counting the victim as free
  assign free    = ~valid | (do_evict ? vsel : '0);
  assign slot_oh = free & (~free + ENTRIES'(1));
  assign ins     = do_ins && (|free);
  assign inc_all = ins && !do_evict;
  assign thr     = do_touch ? frank : vrank;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      occupied <= '0;
    end else begin
      if (ins) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_oh[i]) begin
            valid[i] <= 1'b1;
          end else if (do_evict && vsel[i]) begin
            valid[i] <= 1'b0;
          end
        end
        if (!do_evict) begin
          occupied <= occupied + OCC_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (do_touch) begin
        if (match[i]) begin
          erank[i] <= '0;
          if (ecount[i] != CNT_MAX) begin
            ecount[i] <= ecount[i] + CNT_W'(1);
          end
          if (!is_get) begin
            evalue[i] <= req.value;
          end
        end else if (valid[i] && (erank[i] < thr)) begin
          erank[i] <= erank[i] + IDX_W'(1);
        end
      end else if (ins) begin
        if (slot_oh[i]) begin
          ekey[i]   <= req.key;
          evalue[i] <= req.value;
          ecount[i] <= CNT_W'(1);
          erank[i]  <= '0;
        end else if (valid[i] && !(do_evict && vsel[i]) &&
                     (inc_all || (erank[i] < thr))) begin
          erank[i] <= erank[i] + IDX_W'(1);
        end
      end
    end
  end

  always_comb begin
    rsp             = '0;
    rsp.hit         = found;
    rsp.read_value  = (is_get && found) ? fval : '0;
    rsp.evicted     = do_evict;
    rsp.evicted_key = do_evict ? vkey : '0;
  end

endmodule

### hdl/lfu_cache_controller_unit.sv
// Channel   Signals                     Transaction
// request   start, busy, req            start && !busy at a rising edge
// result    done, result                done high for one cycle, no stall
// config    psel, penable, pwrite, ...  APB write, capacity at address 0
//
// One request per cycle; busy is always low. An accepted request loads the input
// register, then the result register after one pass through key compare, victim
// search and entry update; done is loaded along with the result register and
// marks when the result may be taken.
// Synchronous reset clears all entries at once; capacity returns to 16.
// The result side cannot stall, so nothing holds the request side.
`include "lfu_cache_controller_unit_defines.svh"

module lfu_cache_controller_unit #(
  parameter int ENTRIES = lfu_pkg::ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  lfu_pkg::req_t               req,
  output logic                        done,
  output lfu_pkg::rsp_t               result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lfu_pkg::APB_AW-1:0]  paddr,
  input  logic [lfu_pkg::APB_DW-1:0]  pwdata,
  output logic [lfu_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import lfu_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W = $clog2(ENTRIES + 1);

  logic [CAP_W-1:0]   capacity;
  logic [OCC_W-1:0]   cap_eff;
  logic               in_vld;
  req_t               req_q;
  rsp_t               rsp;
  logic [ENTRIES-1:0] st_valid;
  logic [OCC_W-1:0]   st_occ;

  assign busy = 1'b0;

  lfu_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  always_comb begin
    if (int'(capacity) > ENTRIES) begin
      cap_eff = OCC_W'(ENTRIES);
    end else begin
      cap_eff = OCC_W'(capacity);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      in_vld <= start && !busy;
      done   <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_q <= req;
    end
    if (in_vld) begin
      result <= rsp;
    end
  end

  lfu_store #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W),
    .OCC_W   (OCC_W)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (in_vld),
    .req      (req_q),
    .cap_eff  (cap_eff),
    .rsp      (rsp),
    .valid    (st_valid),
    .occupied (st_occ)
  );

  `LFU_ASSERT_NEXT(a_done_follows, clk, rst, in_vld, done, "result strobe missing")
  `LFU_ASSERT_NOW(a_evict_on_miss, clk, rst, done && result.evicted, !result.hit, "evict on hit")
  `LFU_ASSERT_NOW(a_occ_count, clk, rst, 1'b1, $countones(st_valid) == int'(st_occ), "occupancy")

endmodule
